// ===== sv/pvh_pkg.sv =====
// Package for the projected value histogram unit.
// Holds field widths, op codes, register indexes, defaults and the sequencer state type.
// No dependencies.
package pvh_pkg;

	localparam int OP_W        = 2;
	localparam int VALUE_W     = 16;
	localparam int BIN_NUM_W   = 7;
	localparam int CNT_OUT_W   = 20;
	localparam int DIMS_W      = 3;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int NUM_COMPS   = 4;
	localparam int COMP_IDX_W  = 2;
	localparam int ACC_W       = 34;
	localparam int MUL_W       = 33;
	localparam int PROD_W      = 66;
	localparam int Q_W         = 19;

	localparam int DEF_BIN_COUNT  = 128;
	localparam int DEF_MAX_DIMS   = 4;
	localparam int DEF_COUNT_BITS = 20;

	localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd4;

	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] REG_WEIGHT_0 = 3'd0;
	localparam logic [2:0] REG_WEIGHT_1 = 3'd1;
	localparam logic [2:0] REG_WEIGHT_2 = 3'd2;
	localparam logic [2:0] REG_WEIGHT_3 = 3'd3;
	localparam logic [2:0] REG_DIMS     = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAC,
		S_DRAIN,
		S_SQUARE,
		S_RANGE,
		S_SCALE,
		S_QSUM,
		S_ROOT_MUL,
		S_ROOT_CMP,
		S_BIN,
		S_RDMEM,
		S_UPD
	} state_t;

endpackage

// ===== sv/projected_value_histogram_unit.sv =====
// Projected value histogram unit: dot product of a record with configured weights,
// exact binning against +/- sqrt(2), saturating bin counts and record total.
// Depends on pvh_pkg.
//
// Usage: configuration over the APB port (weights and dims_in_use, written while idle).
// An operation is taken when start is high and busy is low; op selects add, read or clear.
// Every add, read or clear gives one result beat: done is high for exactly one cycle with
// bin_number, bin_count and record_total; the receiver cannot stall, so nothing waits.
// Op code 3 is dropped with no result.
// Sequence of an operation:
//   add   : one product per active dimension, then the square, the range check, the
//           scaling and the square root; once |f| >= sqrt(2) it skips to the edge bin.
//           One shared 33x33 multiplier does the products, the square, the bin scaling
//           and every square-root trial.
//   read  : registered bin memory read.
//   clear : per-bin valid flags clear at once.
// busy stays high for the whole add or read (a clear never raises it); the next one can be taken in the done cycle.
// Reset clears weights, sets dims_in_use to 4, and empties all bins and the total.
module projected_value_histogram_unit #(
	parameter int BIN_COUNT  = pvh_pkg::DEF_BIN_COUNT,
	parameter int MAX_DIMS   = pvh_pkg::DEF_MAX_DIMS,
	parameter int COUNT_BITS = pvh_pkg::DEF_COUNT_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pvh_pkg::ADDR_W-1:0]          paddr,
	input  logic [pvh_pkg::DATA_W-1:0]          pwdata,
	output logic [pvh_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	input  logic                                start,
	output logic                                busy,
	input  logic [pvh_pkg::OP_W-1:0]            op,
	input  logic signed [pvh_pkg::VALUE_W-1:0]  value_0,
	input  logic signed [pvh_pkg::VALUE_W-1:0]  value_1,
	input  logic signed [pvh_pkg::VALUE_W-1:0]  value_2,
	input  logic signed [pvh_pkg::VALUE_W-1:0]  value_3,
	input  logic [pvh_pkg::BIN_NUM_W-1:0]       read_bin,
	output logic                                done,
	output logic [pvh_pkg::BIN_NUM_W-1:0]       bin_number,
	output logic [pvh_pkg::CNT_OUT_W-1:0]       bin_count,
	output logic [pvh_pkg::CNT_OUT_W-1:0]       record_total
);
	import pvh_pkg::*;

	localparam int BI      = $clog2(BIN_COUNT);
	localparam int MW      = BI;
	localparam int BITW    = (MW > 1) ? $clog2(MW) : 1;
	localparam int HALF    = BIN_COUNT / 2;
	localparam int ACT_LIM = (MAX_DIMS < NUM_COMPS) ? MAX_DIMS : NUM_COMPS;

	localparam logic [MUL_W-1:0]      SQ_BINS   = MUL_W'(BIN_COUNT * BIN_COUNT);
	localparam logic [BI:0]           HALF_V    = (BI+1)'(HALF);
	localparam logic [BI:0]           TOP_V     = (BI+1)'(BIN_COUNT - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
	localparam logic [DIMS_W-1:0]     LIM_V     = DIMS_W'(ACT_LIM);

	state_t state_q, nxt_state;

	logic signed [VALUE_W-1:0] weight_q [NUM_COMPS];
	logic [DIMS_W-1:0]         dims_q;
	logic signed [VALUE_W-1:0] val_q [NUM_COMPS];
	logic [COMP_IDX_W-1:0]     idx_q;
	logic                      acc_en_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [31:0]               a2lo_q;
	logic [44:0]               hip_q;
	logic [Q_W-1:0]            q_q;
	logic [MW-1:0]             m_q;
	logic [BITW-1:0]           bit_q;
	logic [BI-1:0]             bin_q;
	logic                      is_read_q;
	logic                      rd_ok_q;
	logic [BIN_NUM_W-1:0]      read_bin_q;
	logic [BIN_COUNT-1:0]      valid_q;
	logic [COUNT_BITS-1:0]     total_q;
	logic [COUNT_BITS-1:0]     mem [BIN_COUNT];
	logic [COUNT_BITS-1:0]     rdata_q;
	logic                      done_q;
	logic [BIN_NUM_W-1:0]      bin_number_q;
	logic [CNT_OUT_W-1:0]      bin_count_q;
	logic [CNT_OUT_W-1:0]      record_total_q;

	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic                    mem_we;
	logic                    accept;
	logic                    cfg_wr;
	logic [DIMS_W-1:0]       n_dims;
	logic [ACC_W-1:0]        mag;
	logic                    neg;
	logic                    big;
	logic [MW-1:0]           trial;
	logic [45:0]             q_sum;
	logic [BI:0]             bin_calc;
	logic [BI:0]             m_ext;
	logic [COUNT_BITS-1:0]   cnt_cur, cnt_new, total_new;

	assign accept = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign busy   = (state_q != S_IDLE);

	assign n_dims = (dims_q > LIM_V) ? LIM_V : dims_q;
	assign neg    = acc_q[ACC_W-1];
	assign mag    = neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign big    = (mag[ACC_W-1:32] != '0) || (prod_q[63:57] != '0);
	assign trial  = m_q | (MW'(1) << bit_q);
	assign q_sum  = 46'(hip_q) + 46'(prod_q[51:32]);
	assign m_ext  = (BI+1)'(m_q);

	always_comb begin
		if (neg)
			bin_calc = (m_ext > HALF_V) ? '0 : HALF_V - m_ext;
		else
			bin_calc = (HALF_V + m_ext > TOP_V) ? TOP_V : HALF_V + m_ext;
	end

	assign cnt_cur   = valid_q[bin_q] ? rdata_q : '0;
	assign cnt_new   = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
	assign total_new = (total_q == CNT_MAX) ? total_q : total_q + 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COMPS; i++)
				weight_q[i] <= '0;
			dims_q <= DIMS_RESET;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_WEIGHT_0: weight_q[0] <= pwdata[VALUE_W-1:0];
				REG_WEIGHT_1: weight_q[1] <= pwdata[VALUE_W-1:0];
				REG_WEIGHT_2: weight_q[2] <= pwdata[VALUE_W-1:0];
				REG_WEIGHT_3: weight_q[3] <= pwdata[VALUE_W-1:0];
				REG_DIMS:     dims_q      <= pwdata[DIMS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_WEIGHT_0: prdata = DATA_W'($unsigned(weight_q[0]));
			REG_WEIGHT_1: prdata = DATA_W'($unsigned(weight_q[1]));
			REG_WEIGHT_2: prdata = DATA_W'($unsigned(weight_q[2]));
			REG_WEIGHT_3: prdata = DATA_W'($unsigned(weight_q[3]));
			REG_DIMS:     prdata = DATA_W'(dims_q);
			default:      prdata = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= nxt_state;
	end

	always_comb begin
		nxt_state = state_q;
		mul_a     = '0;
		mul_b     = '0;
		mem_we    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op)
						OP_ADD:   nxt_state = (n_dims == '0) ? S_SQUARE : S_MAC;
						OP_READ:  nxt_state = S_RDMEM;
						default:  nxt_state = S_IDLE;
					endcase
				end
			end
			S_MAC: begin
				mul_a = MUL_W'(weight_q[idx_q]);
				mul_b = MUL_W'(val_q[idx_q]);
				if (DIMS_W'(idx_q) == n_dims - 1'b1)
					nxt_state = S_DRAIN;
			end
			S_DRAIN: nxt_state = S_SQUARE;
			S_SQUARE: begin
				mul_a     = $signed({1'b0, mag[31:0]});
				mul_b     = $signed({1'b0, mag[31:0]});
				nxt_state = S_RANGE;
			end
			S_RANGE: begin
				mul_a     = $signed(SQ_BINS);
				mul_b     = $signed({8'b0, prod_q[56:32]});
				nxt_state = big ? S_RDMEM : S_SCALE;
			end
			S_SCALE: begin
				mul_a     = $signed(SQ_BINS);
				mul_b     = $signed({1'b0, a2lo_q});
				nxt_state = S_QSUM;
			end
			S_QSUM: nxt_state = S_ROOT_MUL;
			S_ROOT_MUL: begin
				mul_a     = $signed(MUL_W'(trial));
				mul_b     = $signed(MUL_W'(trial));
				nxt_state = S_ROOT_CMP;
			end
			S_ROOT_CMP: nxt_state = (bit_q == '0) ? S_BIN : S_ROOT_MUL;
			S_BIN:      nxt_state = S_RDMEM;
			S_RDMEM:    nxt_state = S_UPD;
			S_UPD: begin
				mem_we    = !is_read_q;
				nxt_state = S_IDLE;
			end
			default: nxt_state = S_IDLE;
		endcase
	end

	// shared multiplier
	always_ff @(posedge clk)
		prod_q <= mul_a * mul_b;

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q[0]   <= value_0;
			val_q[1]   <= value_1;
			val_q[2]   <= value_2;
			val_q[3]   <= value_3;
			read_bin_q <= read_bin;
			rd_ok_q    <= (32'(read_bin) < 32'(BIN_COUNT));
			is_read_q  <= (op == OP_READ);
			bin_q      <= BI'(read_bin);
			idx_q      <= '0;
			acc_q      <= '0;
		end else begin
			if (acc_en_q)
				acc_q <= acc_q + ACC_W'(prod_q);
			if (state_q == S_MAC)
				idx_q <= idx_q + 1'b1;
			if (state_q == S_RANGE) begin
				a2lo_q <= prod_q[31:0];
				if (big)
					bin_q <= neg ? '0 : BI'(BIN_COUNT - 1);
			end
			if (state_q == S_SCALE)
				hip_q <= prod_q[44:0];
			if (state_q == S_QSUM) begin
				q_q   <= q_sum[45:27];
				m_q   <= '0;
				bit_q <= BITW'(MW - 1);
			end
			if (state_q == S_ROOT_CMP) begin
				if ($unsigned(prod_q) <= PROD_W'(q_q))
					m_q <= trial;
				if (bit_q != '0)
					bit_q <= bit_q - 1'b1;
			end
			if (state_q == S_BIN)
				bin_q <= bin_calc[BI-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_en_q <= 1'b0;
		else
			acc_en_q <= (state_q == S_MAC);
	end

	// bin store
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[bin_q] <= cnt_new;
		rdata_q <= mem[bin_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (accept && op == OP_CLEAR) || (state_q == S_UPD);
			if (accept && op == OP_CLEAR) begin
				valid_q <= '0;
				total_q <= '0;
			end else if (state_q == S_UPD && !is_read_q) begin
				valid_q[bin_q] <= 1'b1;
				total_q        <= total_new;
			end
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (accept && op == OP_CLEAR) begin
			bin_number_q   <= '0;
			bin_count_q    <= '0;
			record_total_q <= '0;
		end else if (state_q == S_UPD) begin
			if (is_read_q) begin
				bin_number_q   <= read_bin_q;
				bin_count_q    <= rd_ok_q ? CNT_OUT_W'(cnt_cur) : '0;
				record_total_q <= CNT_OUT_W'(total_q);
			end else begin
				bin_number_q   <= BIN_NUM_W'(bin_q);
				bin_count_q    <= CNT_OUT_W'(cnt_new);
				record_total_q <= CNT_OUT_W'(total_new);
			end
		end
	end

	assign done         = done_q;
	assign bin_number   = bin_number_q;
	assign bin_count    = bin_count_q;
	assign record_total = record_total_q;

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result beat without an operation");

	a_root_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT_CMP) |-> $past(state_q == S_ROOT_MUL))
		else $error("root compare without a trial product");

	a_add_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && !is_read_q) |=> valid_q[$past(bin_q)] && (total_q != '0))
		else $error("add did not mark bin or count record");

endmodule
